@@ src/mfv_pkg.sv @@
package mfv_pkg;

  localparam int unsigned VALUE_W        = 7;
  localparam int unsigned DEF_VALUE_BINS = 128;
  localparam int unsigned DEF_MAX_ITEMS  = 65536;

  typedef struct packed {
    logic upd;
    logic clear;
  } ldr_ctrl_t;

endpackage

@@ src/mfv_in_if.sv @@
interface mfv_in_if;
  import mfv_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic               last_item;

  modport source (output valid, sample_value, last_item, input ready);
  modport sink   (input valid, sample_value, last_item, output ready);

endinterface

@@ src/mfv_out_if.sv @@
interface mfv_out_if #(
  parameter int unsigned CNT_W = $clog2(mfv_pkg::DEF_MAX_ITEMS + 1)
);
  import mfv_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] mode_value;
  logic [CNT_W-1:0]   mode_count;

  modport source (output valid, mode_value, mode_count, input ready);
  modport sink   (input valid, mode_value, mode_count, output ready);

endinterface

@@ src/mfv_ram.sv @@
module mfv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mfv_leader.sv @@
module mfv_leader #(
  parameter int unsigned CNT_W     = 17,
  parameter int unsigned POS_W     = 16,
  parameter int unsigned MAX_ITEMS = mfv_pkg::DEF_MAX_ITEMS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mfv_pkg::ldr_ctrl_t         ctrl_i,
  input  logic [mfv_pkg::VALUE_W-1:0] value_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [POS_W-1:0]           first_i,
  output logic [POS_W-1:0]           pos_o,
  output logic [mfv_pkg::VALUE_W-1:0] mode_value_o,
  output logic [CNT_W-1:0]           mode_count_o
);
  import mfv_pkg::*;

  localparam logic [POS_W-1:0] PosMax = POS_W'(MAX_ITEMS - 1);

  logic [VALUE_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [POS_W-1:0]   first_q, first_d;
  logic [POS_W-1:0]   pos_q;

  always_comb begin
    value_d = value_q;
    count_d = count_q;
    first_d = first_q;
    if (value_i == value_q && count_q != '0) begin
      count_d = count_i;
    end else if (count_i > count_q || (count_i == count_q && first_i < first_q)) begin
      value_d = value_i;
      count_d = count_i;
      first_d = first_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      count_q <= '0;
      first_q <= '0;
      pos_q   <= '0;
    end else if (ctrl_i.upd) begin
      if (ctrl_i.clear) begin
        value_q <= '0;
        count_q <= '0;
        first_q <= '0;
        pos_q   <= '0;
      end else begin
        value_q <= value_d;
        count_q <= count_d;
        first_q <= first_d;
        if (pos_q < PosMax) begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  assign pos_o        = pos_q;
  assign mode_value_o = value_d;
  assign mode_count_o = count_d;

endmodule

@@ src/most_frequent_value_finder.sv @@
// channel    | port      | dir | beat payload
// -----------+-----------+-----+------------------------------
// sample     | sample_i  | in  | sample_value[6:0], last_item
// mode       | mode_o    | out | mode_value[6:0], mode_count[CNT_W-1:0]
//
// One sample per cycle unless stalled: bin read in the accept cycle, update and write back in s1.
// The back-to-back hit on the same bin is served from the last written entry.
// A result is registered as its last sample leaves s1; the output register frees the input side.
// A last sample waits in the update stage only while a result is held unread.
// Reset clears per-bin valid bits at once; no clearing pass, sample accepted right after reset.
module most_frequent_value_finder #(
  parameter int unsigned VALUE_BINS = mfv_pkg::DEF_VALUE_BINS,
  parameter int unsigned MAX_ITEMS  = mfv_pkg::DEF_MAX_ITEMS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfv_in_if.sink    sample_i,
  mfv_out_if.source mode_o
);
  import mfv_pkg::*;

  localparam int unsigned BIN_W     = (VALUE_BINS > 1) ? $clog2(VALUE_BINS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned POS_W     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned ENT_W     = POS_W + CNT_W;
  localparam int unsigned NUM_CODES = 2 ** VALUE_W;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_ITEMS);

  logic [BIN_W-1:0] bin_lut [NUM_CODES];

  for (genvar g = 0; g < NUM_CODES; g++) begin : g_bin_lut
    assign bin_lut[g] = BIN_W'(g % VALUE_BINS);
  end

  logic             accept;
  logic [BIN_W-1:0] in_bin;
  logic             s1_go;
  logic             s1_valid_q, s1_last_q, s1_hit_q, s1_vld_q;
  logic [BIN_W-1:0] s1_bin_q;
  logic [ENT_W-1:0] fwd_q;
  logic [ENT_W-1:0] ram_rdata;
  logic [ENT_W-1:0] rd_ent;
  logic [CNT_W-1:0] cur_cnt, new_cnt;
  logic [POS_W-1:0] cur_first, new_first;
  logic [ENT_W-1:0] wr_ent;
  logic [VALUE_BINS-1:0] bin_vld_q;
  logic             hit_d, vld_d;

  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] ldr_value;
  logic [CNT_W-1:0]   ldr_count;
  ldr_ctrl_t          ldr_ctrl;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [CNT_W-1:0]   out_count_q;

  assign in_bin          = bin_lut[sample_i.sample_value];
  assign s1_go           = s1_valid_q && (!s1_last_q || !out_valid_q || mode_o.ready);
  assign sample_i.ready  = !s1_valid_q || s1_go;
  assign accept          = sample_i.valid && sample_i.ready;

  assign hit_d = s1_go && !s1_last_q && (s1_bin_q == in_bin);
  assign vld_d = bin_vld_q[in_bin] && !(s1_go && s1_last_q);

  mfv_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VALUE_BINS)
  ) u_mfv_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_bin_q),
    .wdata_i (wr_ent),
    .re_i    (accept),
    .raddr_i (in_bin),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_ent    = s1_hit_q ? fwd_q : ram_rdata;
    cur_cnt   = (s1_hit_q || s1_vld_q) ? rd_ent[CNT_W-1:0] : '0;
    cur_first = rd_ent[ENT_W-1:CNT_W];
    new_first = (cur_cnt == '0) ? pos : cur_first;
    new_cnt   = (cur_cnt < CntMax) ? cur_cnt + 1'b1 : cur_cnt;
    wr_ent    = {new_first, new_cnt};
  end

  assign ldr_ctrl.upd   = s1_go;
  assign ldr_ctrl.clear = s1_last_q;

  mfv_leader #(
    .CNT_W     (CNT_W),
    .POS_W     (POS_W),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_mfv_leader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ldr_ctrl),
    .value_i      (VALUE_W'(s1_bin_q)),
    .count_i      (new_cnt),
    .first_i      (new_first),
    .pos_o        (pos),
    .mode_value_o (ldr_value),
    .mode_count_o (ldr_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_hit_q    <= 1'b0;
      s1_vld_q    <= 1'b0;
      bin_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_last_q  <= sample_i.last_item;
        s1_hit_q   <= hit_d;
        s1_vld_q   <= vld_d;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last_q) begin
          bin_vld_q <= '0;
        end else begin
          bin_vld_q[s1_bin_q] <= 1'b1;
        end
      end
      if (s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (mode_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bin_q <= in_bin;
    end
    if (s1_go) begin
      fwd_q <= wr_ent;
    end
    if (s1_go && s1_last_q) begin
      out_value_q <= ldr_value;
      out_count_q <= ldr_count;
    end
  end

  assign mode_o.valid      = out_valid_q;
  assign mode_o.mode_value = out_value_q;
  assign mode_o.mode_count = out_count_q;

endmodule

@@ src/mfv_checker.sv @@
module mfv_checker #(
  parameter int unsigned MAX_ITEMS = mfv_pkg::DEF_MAX_ITEMS,
  parameter int unsigned CNT_W     = 17
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mfv_pkg::VALUE_W-1:0] out_value_i,
  input logic [CNT_W-1:0]            out_count_i
);
  import mfv_pkg::*;

  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_ITEMS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_count_i))
    else $error("result beat changed while stalled");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i != '0)
    else $error("result carries a zero count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= CntMax)
    else $error("result count above saturation limit");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no result pending");

  a_no_spurious_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_i |=> in_ready_i)
    else $error("input stalled after idle cycle");

endmodule

bind most_frequent_value_finder mfv_checker #(
  .MAX_ITEMS (MAX_ITEMS),
  .CNT_W     (CNT_W)
) u_mfv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (mode_o.valid),
  .out_ready_i (mode_o.ready),
  .out_value_i (mode_o.mode_value),
  .out_count_i (mode_o.mode_count)
);
